### rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, constants and helpers of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int SLOT_N       = 32;
    localparam int SLOT_W       = $clog2(SLOT_N);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int TOKENS       = 4;
    localparam int PRICE_LEVELS = 256;
    localparam int TOK_W        = 2;
    localparam int PRICE_W      = 8;
    localparam int QTY_W        = 31;
    localparam int ID_W         = 32;
    localparam int SEQ_W        = 32;
    localparam int LV_W         = TOK_W + 1 + PRICE_W;
    localparam int LV_N         = 1 << LV_W;
    localparam int OCC_BITS     = 64;
    localparam int BIT_W        = $clog2(OCC_BITS);
    localparam int OCC_N        = LV_N / OCC_BITS;
    localparam int OCC_W        = LV_W - BIT_W;
    localparam int PW_W         = PRICE_W - BIT_W;
    localparam int MAX_RES      = 64;
    localparam int CNT_W        = $clog2(MAX_RES) + 1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOT_N);

    typedef enum logic [1:0] {
        REQ_NEW  = 2'd0,
        REQ_MOD  = 2'd1,
        REQ_CAN  = 2'd2,
        REQ_NONE = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        MSG_NEW    = 2'd0,
        MSG_CANCEL = 2'd1,
        MSG_TRADE  = 2'd2,
        MSG_REJECT = 2'd3
    } msg_kind_t;

    typedef struct packed {
        req_kind_t          kind;
        logic [TOK_W-1:0]   tok;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    ref_id;
    } req_t;

    typedef struct packed {
        msg_kind_t          kind;
        logic [SEQ_W-1:0]   seq;
        logic [ID_W-1:0]    id;
        logic [TOK_W-1:0]   tok;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               last;
    } msg_t;

    typedef struct packed {
        logic               side;
        logic [TOK_W-1:0]   tok;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    id;
    } slot_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_EMIT_REJ,
        S_EMIT_CAN,
        S_RELOAD,
        S_EMIT_NEW,
        S_UL0,
        S_UL1,
        S_AP0,
        S_AP1,
        S_AP2,
        S_M_START,
        S_M_SCAN,
        S_M_HEAD,
        S_M_SLOT,
        S_M_FILL,
        S_M_T1,
        S_M_T2,
        S_M_END,
        S_FINISH
    } eng_state_t;

    function automatic logic [LV_W-1:0] lvl(input logic [TOK_W-1:0] tok,
                                            input logic side,
                                            input logic [PRICE_W-1:0] price);
        return {tok, side, price};
    endfunction

endpackage

### rtl/lobm_front.sv
// ----------------------------------------------------------------------------
// lobm_front
// Accepts request items, decodes and saturates them, and queues them for
// the matching engine. Unused request types are dropped here.
// ----------------------------------------------------------------------------
module lobm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_type,
    input  logic [79:0]         in_data,
    output logic                q_valid,
    output lobm_pkg::req_t      q_data,
    input  logic                q_pop
);
    import lobm_pkg::*;

    req_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       cls;
    logic       push;

    always_comb begin
        cls.kind   = req_kind_t'(in_type);
        cls.tok    = in_data[1:0];
        cls.side   = in_data[2];
        cls.price  = in_data[10:3];
        cls.qty    = in_data[41:11];
        cls.ref_id = in_data[73:42];
        if ({30'd0, cls.tok} >= TOKENS) begin
            cls.tok = TOK_W'(TOKENS - 1);
        end
        if ({24'd0, cls.price} >= PRICE_LEVELS) begin
            cls.price = PRICE_W'(PRICE_LEVELS - 1);
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (cls.kind != REQ_NONE);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !(q_pop && q_valid)) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop && q_valid) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

### rtl/lobm_out_fifo.sv
// ----------------------------------------------------------------------------
// lobm_out_fifo
// Two-entry message queue that decouples the engine from the result stream.
// ----------------------------------------------------------------------------
module lobm_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  lobm_pkg::msg_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output lobm_pkg::msg_t  rd_data
);
    import lobm_pkg::*;

    msg_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!do_wr && do_rd) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/lobm_engine.sv
// ----------------------------------------------------------------------------
// lobm_engine
// Back end: order pool, per-level FIFO chains, occupancy map and the
// sequencer that books, cancels and matches orders and emits messages.
// ----------------------------------------------------------------------------
module lobm_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  lobm_pkg::req_t  q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output lobm_pkg::msg_t  out_data
);
    import lobm_pkg::*;

    // storage
    slot_t               slot_mem  [SLOT_N];
    logic [LINK_W-1:0]   link_prev [SLOT_N];
    logic [LINK_W-1:0]   link_next [SLOT_N];
    logic [SLOT_W-1:0]   head_mem  [LV_N];
    logic [SLOT_W-1:0]   tail_mem  [LV_N];
    logic [OCC_BITS-1:0] occ_reg   [OCC_N];
    logic [SLOT_N-1:0]   valid_reg;

    // registered read data
    slot_t             rd_reg;
    logic [SLOT_W-1:0] head_rd_reg, tail_rd_reg;
    logic [LINK_W-1:0] lp_reg, ln_reg;

    eng_state_t          state_reg, state_next;
    eng_state_t          ret_reg, ret_next;
    req_t                req_reg, req_next;
    slot_t               me_reg, me_next;
    logic [SLOT_W-1:0]   me_slot_reg, me_slot_next;
    logic [SLOT_W-1:0]   scan_reg, scan_next;
    logic [SLOT_W-1:0]   ul_slot_reg, ul_slot_next;
    logic [SLOT_W-1:0]   h_reg, h_next;
    logic [LV_W-1:0]     lv_reg, lv_next;
    logic [PW_W-1:0]     pw_reg, pw_next;
    logic [QTY_W-1:0]    rem_reg, rem_next;
    logic                orig_nz_reg, orig_nz_next;
    logic [QTY_W-1:0]    fill_reg, fill_next;
    logic [ID_W-1:0]     bid_reg, bid_next;
    logic [ID_W-1:0]     ask_reg, ask_next;
    logic [PRICE_W-1:0]  tprice_reg, tprice_next;
    logic [LINK_W-1:0]   t_reg, t_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    msg_t                pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;

    // write controls
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    slot_t             slot_wdata;
    logic [SLOT_W-1:0] slot_raddr;
    logic              valid_set, valid_clr;
    logic [SLOT_W-1:0] valid_idx;
    logic              lnext_we, lprev_we;
    logic [SLOT_W-1:0] lnext_addr, lprev_addr;
    logic [LINK_W-1:0] lnext_data, lprev_data;
    logic              head_we, tail_we;
    logic [SLOT_W-1:0] head_data, tail_data;
    logic              occ_set, occ_clr;
    logic [OCC_W-1:0]  occ_raddr;
    logic [OCC_BITS-1:0] occ_word;

    // emit controls
    logic em_req, em_do, em_stall;
    msg_t em_msg;

    // helpers
    logic [SLOT_W-1:0]   free_idx;
    logic                pool_full;
    logic                buy;
    logic                opp;
    logic                at_lim;
    logic [PW_W-1:0]     lim_pw;
    logic [BIT_W-1:0]    lo;
    logic [OCC_BITS-1:0] masked;
    logic                hit;
    logic [BIT_W-1:0]    hit_bit;
    logic [LINK_W-1:0]   t_cur;

    always_comb begin
        free_idx = '0;
        for (int i = SLOT_N - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end
    assign pool_full = &valid_reg;

    assign buy      = me_reg.side;
    assign opp      = ~me_reg.side;
    assign lim_pw   = me_reg.price[PRICE_W-1:BIT_W];
    assign lo       = me_reg.price[BIT_W-1:0];
    assign at_lim   = (pw_reg == lim_pw);
    assign occ_word = occ_reg[occ_raddr];

    always_comb begin
        masked = occ_word;
        if (at_lim) begin
            if (buy) begin
                masked = occ_word & ({OCC_BITS{1'b1}} >> (BIT_W'(OCC_BITS - 1) - lo));
            end else begin
                masked = occ_word & ({OCC_BITS{1'b1}} << lo);
            end
        end
        hit     = |masked;
        hit_bit = '0;
        if (buy) begin
            for (int i = OCC_BITS - 1; i >= 0; i--) begin
                if (masked[i]) begin
                    hit_bit = BIT_W'(i);
                end
            end
        end else begin
            for (int i = 0; i < OCC_BITS; i++) begin
                if (masked[i]) begin
                    hit_bit = BIT_W'(i);
                end
            end
        end
    end

    assign t_cur = occ_word[lv_reg[BIT_W-1:0]] ? {1'b0, tail_rd_reg} : NIL;

    assign em_do    = em_req && !cnt_reg[CNT_W-1];
    assign em_stall = em_do && pend_valid_reg && !out_ready;

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        req_next        = req_reg;
        me_next         = me_reg;
        me_slot_next    = me_slot_reg;
        scan_next       = scan_reg;
        ul_slot_next    = ul_slot_reg;
        h_next          = h_reg;
        lv_next         = lv_reg;
        pw_next         = pw_reg;
        rem_next        = rem_reg;
        orig_nz_next    = orig_nz_reg;
        fill_next       = fill_reg;
        bid_next        = bid_reg;
        ask_next        = ask_reg;
        tprice_next     = tprice_reg;
        t_next          = t_reg;
        next_id_next    = next_id_reg;
        seq_next        = seq_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;

        q_pop      = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = me_slot_reg;
        slot_wdata = me_reg;
        slot_raddr = scan_reg;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        valid_idx  = me_slot_reg;
        lnext_we   = 1'b0;
        lprev_we   = 1'b0;
        lnext_addr = me_slot_reg;
        lprev_addr = me_slot_reg;
        lnext_data = NIL;
        lprev_data = NIL;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        head_data  = me_slot_reg;
        tail_data  = me_slot_reg;
        occ_set    = 1'b0;
        occ_clr    = 1'b0;
        occ_raddr  = lv_reg[LV_W-1:BIT_W];

        out_valid  = 1'b0;
        out_data   = pend_reg;
        em_req     = 1'b0;
        em_msg     = '0;

        unique case (state_reg)
            S_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    req_next = q_data;
                    unique case (q_data.kind)
                        REQ_NEW: begin
                            if (pool_full) begin
                                state_next = S_EMIT_REJ;
                            end else begin
                                me_next.side  = q_data.side;
                                me_next.tok   = q_data.tok;
                                me_next.price = q_data.price;
                                me_next.qty   = q_data.qty;
                                me_next.id    = next_id_reg;
                                me_slot_next  = free_idx;
                                next_id_next  = next_id_reg + 1'b1;
                                slot_we       = 1'b1;
                                slot_waddr    = free_idx;
                                slot_wdata    = me_next;
                                valid_set     = 1'b1;
                                valid_idx     = free_idx;
                                lv_next       = lvl(q_data.tok, q_data.side, q_data.price);
                                state_next    = S_AP0;
                            end
                        end
                        REQ_MOD, REQ_CAN: begin
                            scan_next  = '0;
                            state_next = S_FIND_RD;
                        end
                        REQ_NONE: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (valid_reg[scan_reg] && (rd_reg.id == req_reg.ref_id)) begin
                    me_next      = rd_reg;
                    me_slot_next = scan_reg;
                    state_next   = S_EMIT_CAN;
                end else if (scan_reg == SLOT_W'(SLOT_N - 1)) begin
                    state_next = S_FINISH;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_EMIT_REJ: begin
                em_req       = 1'b1;
                em_msg.kind  = MSG_REJECT;
                em_msg.id    = '0;
                em_msg.tok   = req_reg.tok;
                em_msg.price = req_reg.price;
                em_msg.qty   = req_reg.qty;
                if (!em_stall) begin
                    state_next = S_FINISH;
                end
            end
            S_EMIT_CAN: begin
                em_req       = 1'b1;
                em_msg.kind  = MSG_CANCEL;
                em_msg.id    = me_reg.id;
                em_msg.tok   = me_reg.tok;
                em_msg.price = me_reg.price;
                em_msg.qty   = me_reg.qty;
                if (!em_stall) begin
                    lv_next      = lvl(me_reg.tok, me_reg.side, me_reg.price);
                    ul_slot_next = me_slot_reg;
                    ret_next     = (req_reg.kind == REQ_MOD) ? S_RELOAD : S_FINISH;
                    state_next   = S_UL0;
                end
            end
            S_RELOAD: begin
                me_next.price = req_reg.price;
                me_next.qty   = req_reg.qty;
                me_next.id    = next_id_reg;
                next_id_next  = next_id_reg + 1'b1;
                slot_we       = 1'b1;
                slot_wdata    = me_next;
                valid_set     = 1'b1;
                lv_next       = lvl(me_reg.tok, me_reg.side, req_reg.price);
                state_next    = S_AP0;
            end
            S_EMIT_NEW: begin
                em_req       = 1'b1;
                em_msg.kind  = MSG_NEW;
                em_msg.id    = me_reg.id;
                em_msg.tok   = me_reg.tok;
                em_msg.price = me_reg.price;
                em_msg.qty   = me_reg.qty;
                if (!em_stall) begin
                    state_next = S_M_START;
                end
            end
            S_UL0: begin
                state_next = S_UL1;
            end
            S_UL1: begin
                if (lp_reg != NIL) begin
                    lnext_we   = 1'b1;
                    lnext_addr = lp_reg[SLOT_W-1:0];
                    lnext_data = ln_reg;
                end else begin
                    head_we   = 1'b1;
                    head_data = ln_reg[SLOT_W-1:0];
                end
                if (ln_reg != NIL) begin
                    lprev_we   = 1'b1;
                    lprev_addr = ln_reg[SLOT_W-1:0];
                    lprev_data = lp_reg;
                end else begin
                    tail_we   = 1'b1;
                    tail_data = lp_reg[SLOT_W-1:0];
                end
                occ_clr    = (lp_reg == NIL) && (ln_reg == NIL);
                valid_clr  = 1'b1;
                valid_idx  = ul_slot_reg;
                state_next = ret_reg;
            end
            S_AP0: begin
                state_next = S_AP1;
            end
            S_AP1: begin
                t_next     = t_cur;
                lprev_we   = 1'b1;
                lprev_data = t_cur;
                lnext_we   = 1'b1;
                lnext_data = NIL;
                if (t_cur == NIL) begin
                    head_we = 1'b1;
                end
                tail_we    = 1'b1;
                occ_set    = 1'b1;
                state_next = S_AP2;
            end
            S_AP2: begin
                if (t_reg != NIL) begin
                    lnext_we   = 1'b1;
                    lnext_addr = t_reg[SLOT_W-1:0];
                    lnext_data = {1'b0, me_slot_reg};
                end
                state_next = S_EMIT_NEW;
            end
            S_M_START: begin
                rem_next     = me_reg.qty;
                orig_nz_next = (me_reg.qty != '0);
                pw_next      = buy ? '0 : '1;
                state_next   = (me_reg.qty == '0) ? S_M_END : S_M_SCAN;
            end
            S_M_SCAN: begin
                occ_raddr = {me_reg.tok, opp, pw_reg};
                if (hit) begin
                    lv_next    = {me_reg.tok, opp, pw_reg, hit_bit};
                    state_next = S_M_HEAD;
                end else if (at_lim) begin
                    state_next = S_M_END;
                end else begin
                    pw_next = buy ? pw_reg + 1'b1 : pw_reg - 1'b1;
                end
            end
            S_M_HEAD: begin
                state_next = S_M_SLOT;
            end
            S_M_SLOT: begin
                slot_raddr = head_rd_reg;
                h_next     = head_rd_reg;
                state_next = S_M_FILL;
            end
            S_M_FILL: begin
                if (buy) begin
                    bid_next    = me_reg.id;
                    ask_next    = rd_reg.id;
                    tprice_next = me_reg.price;
                end else begin
                    bid_next    = rd_reg.id;
                    ask_next    = me_reg.id;
                    tprice_next = rd_reg.price;
                end
                if (rd_reg.qty <= rem_reg) begin
                    fill_next    = rd_reg.qty;
                    rem_next     = rem_reg - rd_reg.qty;
                    ul_slot_next = h_reg;
                    ret_next     = S_M_T1;
                    state_next   = S_UL0;
                end else begin
                    fill_next      = rem_reg;
                    rem_next       = '0;
                    slot_we        = 1'b1;
                    slot_waddr     = h_reg;
                    slot_wdata     = rd_reg;
                    slot_wdata.qty = rd_reg.qty - rem_reg;
                    state_next     = S_M_T1;
                end
            end
            S_M_T1: begin
                em_req       = 1'b1;
                em_msg.kind  = MSG_TRADE;
                em_msg.id    = bid_reg;
                em_msg.tok   = me_reg.tok;
                em_msg.price = tprice_reg;
                em_msg.qty   = fill_reg;
                if (!em_stall) begin
                    state_next = S_M_T2;
                end
            end
            S_M_T2: begin
                em_req       = 1'b1;
                em_msg.kind  = MSG_TRADE;
                em_msg.id    = ask_reg;
                em_msg.tok   = me_reg.tok;
                em_msg.price = tprice_reg;
                em_msg.qty   = fill_reg;
                if (!em_stall) begin
                    pw_next    = buy ? '0 : '1;
                    state_next = (rem_reg == '0) ? S_M_END : S_M_SCAN;
                end
            end
            S_M_END: begin
                if (orig_nz_reg && (rem_reg == '0)) begin
                    lv_next      = lvl(me_reg.tok, me_reg.side, me_reg.price);
                    ul_slot_next = me_slot_reg;
                    ret_next     = S_FINISH;
                    state_next   = S_UL0;
                end else begin
                    slot_we        = 1'b1;
                    slot_wdata     = me_reg;
                    slot_wdata.qty = rem_reg;
                    me_next.qty    = rem_reg;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH: begin
                if (pend_valid_reg) begin
                    out_valid     = 1'b1;
                    out_data.last = 1'b1;
                    if (out_ready) begin
                        pend_valid_next = 1'b0;
                        cnt_next        = '0;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (em_do && !em_stall) begin
            if (pend_valid_reg) begin
                out_valid     = 1'b1;
                out_data.last = 1'b0;
            end
            seq_next        = seq_reg + 1'b1;
            pend_next       = em_msg;
            pend_next.seq   = seq_reg + 1'b1;
            pend_next.last  = 1'b0;
            pend_valid_next = 1'b1;
            cnt_next        = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            next_id_reg    <= '0;
            seq_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= '0;
            for (int i = 0; i < OCC_N; i++) begin
                occ_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            next_id_reg    <= next_id_next;
            seq_reg        <= seq_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (valid_set) begin
                valid_reg[valid_idx] <= 1'b1;
            end
            if (valid_clr) begin
                valid_reg[valid_idx] <= 1'b0;
            end
            if (occ_set) begin
                occ_reg[lv_reg[LV_W-1:BIT_W]][lv_reg[BIT_W-1:0]] <= 1'b1;
            end
            if (occ_clr) begin
                occ_reg[lv_reg[LV_W-1:BIT_W]][lv_reg[BIT_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        me_reg      <= me_next;
        me_slot_reg <= me_slot_next;
        scan_reg    <= scan_next;
        ul_slot_reg <= ul_slot_next;
        h_reg       <= h_next;
        lv_reg      <= lv_next;
        pw_reg      <= pw_next;
        rem_reg     <= rem_next;
        orig_nz_reg <= orig_nz_next;
        fill_reg    <= fill_next;
        bid_reg     <= bid_next;
        ask_reg     <= ask_next;
        tprice_reg  <= tprice_next;
        t_reg       <= t_next;
        pend_reg    <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lnext_we) begin
            link_next[lnext_addr] <= lnext_data;
        end
        if (lprev_we) begin
            link_prev[lprev_addr] <= lprev_data;
        end
        lp_reg <= link_prev[ul_slot_reg];
        ln_reg <= link_next[ul_slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[lv_reg] <= head_data;
        end
        head_rd_reg <= head_mem[lv_reg];
    end

    always_ff @(posedge aclk) begin
        if (tail_we) begin
            tail_mem[lv_reg] <= tail_data;
        end
        tail_rd_reg <= tail_mem[lv_reg];
    end

endmodule

### rtl/limit_order_book_matcher_unit.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority limit order book with new, modify and cancel requests.
// ----------------------------------------------------------------------------
// Requests enter a two-item queue and are worked one at a time by a
// sequencer over the order pool and level chains. A new order is booked,
// then each fill follows a scan of the opposite book one 64-tick word
// at a time; modify and cancel first search the 32-slot pool slot by slot.
// Result items leave through a two-item queue; the final one of each
// request carries tlast. Level chain memories need no clearing after reset.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [79:0]   s_axis_tdata,  // token, side, limit_price, quantity, order_ref
    input  logic [1:0]    s_axis_tuser,  // req_type
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,  // seq_no, msg_order_id, msg_token, msg_price, msg_qty
    output logic [1:0]    m_axis_tuser,  // msg_kind
    output logic          m_axis_tlast
);
    import lobm_pkg::*;

    logic q_valid, q_pop;
    req_t q_data;
    logic eng_valid, eng_ready;
    msg_t eng_data;
    msg_t out_msg;

    lobm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_type  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    lobm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (eng_valid),
        .out_ready (eng_ready),
        .out_data  (eng_data)
    );

    lobm_out_fifo u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (eng_valid),
        .wr_ready (eng_ready),
        .wr_data  (eng_data),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (out_msg)
    );

    assign m_axis_tdata = {7'd0, out_msg.qty, out_msg.price, out_msg.tok,
                           out_msg.id, out_msg.seq};
    assign m_axis_tuser = out_msg.kind;
    assign m_axis_tlast = out_msg.last;

endmodule
